### hw/rtl/tgd_pkg.sv
`timescale 1ns / 1ps

package tgd_pkg;

    localparam logic [31:0] FACE_POLL_MS = 32'd500;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_THRESHOLD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEUTRAL_RATE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN_MS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL_MS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_SETTLE_MS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE_DOWN_MIN      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE_DOWN_MAX_ORTHO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOARD_FLAGS        = 3'd7;

    localparam logic [14:0] RATE_THRESHOLD_RST      = 15'd1600;
    localparam logic [14:0] NEUTRAL_RATE_RST        = 15'd480;
    localparam logic [15:0] COOLDOWN_MS_RST         = 16'd500;
    localparam logic [15:0] POLL_INTERVAL_MS_RST    = 16'd20;
    localparam logic [15:0] WAKE_SETTLE_MS_RST      = 16'd100;
    localparam logic [14:0] FACE_DOWN_MIN_RST       = 15'd7000;
    localparam logic [14:0] FACE_DOWN_MAX_ORTHO_RST = 15'd2500;
    localparam logic [1:0]  BOARD_FLAGS_RST         = 2'd0;

    localparam int FLAG_INVERT_AXIS = 0;
    localparam int FLAG_NEGATE_Z    = 1;

    localparam logic [1:0] PWR_NONE  = 2'd0;
    localparam logic [1:0] PWR_WAKE  = 2'd1;
    localparam logic [1:0] PWR_SLEEP = 2'd2;

    localparam logic [1:0] TMODE_NONE     = 2'd0;
    localparam logic [1:0] TMODE_NORMAL   = 2'd1;
    localparam logic [1:0] TMODE_REVERSED = 2'd2;
    localparam logic [1:0] TMODE_SPARE    = 2'd3;

    localparam logic [1:0] ORIENT_PORTRAIT       = 2'd0;
    localparam logic [1:0] ORIENT_INVERTED       = 2'd1;
    localparam logic [1:0] ORIENT_LANDSCAPE_CW   = 2'd2;
    localparam logic [1:0] ORIENT_LANDSCAPE_CCW  = 2'd3;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic               gyro_ok;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               accel_ok;
        logic [1:0]         tilt_mode;
        logic [1:0]         screen_orientation;
        logic               in_reader;
        logic               watch_face_down;
    } sample_t;

    typedef struct packed {
        logic [1:0]  power_request;
        logic        sensor_awake;
        logic        tilt_forward;
        logic        tilt_back;
        logic        face_down_active;
        logic [31:0] face_down_start;
    } result_t;

endpackage

### hw/rtl/tilt_gesture_detector_core.sv
`timescale 1ns / 1ps
// an accepted item waits in the input stage register; the result register loads from it
// once the output is not stalled, and the result is on the output from then on
// throughput: one item per cycle; input stalls only while a result is held
// reset: detector state cleared, sensor considered asleep, registers take
// their default values, both pipeline stages empty

module tilt_gesture_detector_core
    import tgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [14:0] rate_threshold_reg;
    logic [14:0] neutral_rate_reg;
    logic [15:0] cooldown_ms_reg;
    logic [15:0] poll_interval_ms_reg;
    logic [15:0] wake_settle_ms_reg;
    logic [14:0] face_down_min_reg;
    logic [14:0] face_down_max_ortho_reg;
    logic [1:0]  board_flags_reg;

    logic        awake_reg, awake_next;
    logic        holding_tilt_reg, holding_tilt_next;
    logic        face_down_valid_reg, face_down_valid_next;
    logic [31:0] wake_time_reg, wake_time_next;
    logic [31:0] last_poll_time_reg, last_poll_time_next;
    logic [31:0] last_trigger_time_reg, last_trigger_time_next;
    logic [31:0] last_face_poll_time_reg, last_face_poll_time_next;
    logic [31:0] face_down_since_reg, face_down_since_next;

    logic        stage_valid_reg;
    sample_t     stage_reg;
    logic        result_valid_reg;
    result_t     result_reg, result_next;

    logic        advance;
    logic        fire;

    logic [31:0]        now;
    logic               want;
    logic               wake_cond;
    logic               sleep_cond;
    logic               settled;
    logic               face_poll;
    logic               tilt_poll;
    logic signed [17:0] normal;
    logic signed [17:0] abs_ax;
    logic signed [17:0] abs_ay;
    logic               face_down;
    logic signed [17:0] axis_raw;
    logic signed [17:0] axis;
    logic signed [17:0] abs_axis;
    logic signed [17:0] thr;
    logic               cooled;
    logic               trig_fwd;
    logic               trig_back;

    assign cfg_ready    = 1'b1;
    assign advance      = !result_valid_reg || !result_stall;
    assign fire         = stage_valid_reg && advance;
    assign sample_stall = stage_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        now        = stage_reg.now_ms;
        want       = (stage_reg.tilt_mode != TMODE_NONE) || stage_reg.watch_face_down;
        wake_cond  = want && !awake_reg;
        sleep_cond = !want && awake_reg;
        settled    = (now - wake_time_reg) >= {16'd0, wake_settle_ms_reg};

        face_poll = want && awake_reg && settled && stage_reg.watch_face_down
                    && ((now - last_face_poll_time_reg) >= FACE_POLL_MS);

        normal = board_flags_reg[FLAG_NEGATE_Z] ? -18'(stage_reg.accel_z)
                                                : 18'(stage_reg.accel_z);
        abs_ax = stage_reg.accel_x[15] ? -18'(stage_reg.accel_x) : 18'(stage_reg.accel_x);
        abs_ay = stage_reg.accel_y[15] ? -18'(stage_reg.accel_y) : 18'(stage_reg.accel_y);
        face_down = (normal > $signed({3'd0, face_down_min_reg}))
                    && (abs_ax < $signed({3'd0, face_down_max_ortho_reg}))
                    && (abs_ay < $signed({3'd0, face_down_max_ortho_reg}));

        tilt_poll = want && awake_reg && settled && (stage_reg.tilt_mode != TMODE_NONE)
                    && stage_reg.in_reader
                    && ((now - last_poll_time_reg) >= {16'd0, poll_interval_ms_reg});

        case (stage_reg.screen_orientation)
            ORIENT_PORTRAIT:      axis_raw = 18'(stage_reg.gyro_x);
            ORIENT_INVERTED:      axis_raw = -18'(stage_reg.gyro_x);
            ORIENT_LANDSCAPE_CW:  axis_raw = -18'(stage_reg.gyro_y);
            ORIENT_LANDSCAPE_CCW: axis_raw = 18'(stage_reg.gyro_y);
            default:              axis_raw = 18'(stage_reg.gyro_y);
        endcase
        axis = ((stage_reg.tilt_mode == TMODE_REVERSED) || board_flags_reg[FLAG_INVERT_AXIS])
               ? -axis_raw : axis_raw;
        abs_axis = axis[17] ? -axis : axis;
        thr      = $signed({3'd0, rate_threshold_reg});
        cooled   = (now - last_trigger_time_reg) >= {16'd0, cooldown_ms_reg};

        trig_fwd  = tilt_poll && stage_reg.gyro_ok && !holding_tilt_reg && cooled
                    && (axis > thr);
        trig_back = tilt_poll && stage_reg.gyro_ok && !holding_tilt_reg && cooled
                    && !(axis > thr) && (axis < -thr);

        awake_next               = awake_reg;
        holding_tilt_next        = holding_tilt_reg;
        face_down_valid_next     = face_down_valid_reg;
        wake_time_next           = wake_time_reg;
        last_poll_time_next      = last_poll_time_reg;
        last_trigger_time_next   = last_trigger_time_reg;
        last_face_poll_time_next = last_face_poll_time_reg;
        face_down_since_next     = face_down_since_reg;
        result_next.power_request = PWR_NONE;

        if (wake_cond)
        begin
            awake_next                = 1'b1;
            wake_time_next            = now;
            last_poll_time_next       = now;
            last_trigger_time_next    = now;
            result_next.power_request = PWR_WAKE;
        end
        else if (sleep_cond)
        begin
            awake_next                = 1'b0;
            holding_tilt_next         = 1'b0;
            face_down_valid_next      = 1'b0;
            result_next.power_request = PWR_SLEEP;
        end
        else
        begin
            if (face_poll)
            begin
                last_face_poll_time_next = now;
                if (stage_reg.accel_ok)
                begin
                    if (face_down)
                    begin
                        if (!face_down_valid_reg)
                        begin
                            face_down_valid_next = 1'b1;
                            face_down_since_next = now;
                        end
                    end
                    else
                    begin
                        face_down_valid_next = 1'b0;
                    end
                end
            end
            if (tilt_poll)
            begin
                last_poll_time_next = now;
                if (stage_reg.gyro_ok && holding_tilt_reg && (abs_axis < $signed({3'd0, neutral_rate_reg})))
                begin
                    holding_tilt_next = 1'b0;
                end
                if (trig_fwd || trig_back)
                begin
                    holding_tilt_next      = 1'b1;
                    last_trigger_time_next = now;
                end
            end
        end

        result_next.sensor_awake     = awake_next;
        result_next.tilt_forward     = trig_fwd && !wake_cond && !sleep_cond;
        result_next.tilt_back        = trig_back && !wake_cond && !sleep_cond;
        result_next.face_down_active = face_down_valid_next;
        result_next.face_down_start  = face_down_valid_next ? face_down_since_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_threshold_reg      <= RATE_THRESHOLD_RST;
            neutral_rate_reg        <= NEUTRAL_RATE_RST;
            cooldown_ms_reg         <= COOLDOWN_MS_RST;
            poll_interval_ms_reg    <= POLL_INTERVAL_MS_RST;
            wake_settle_ms_reg      <= WAKE_SETTLE_MS_RST;
            face_down_min_reg       <= FACE_DOWN_MIN_RST;
            face_down_max_ortho_reg <= FACE_DOWN_MAX_ORTHO_RST;
            board_flags_reg         <= BOARD_FLAGS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RATE_THRESHOLD:      rate_threshold_reg      <= cfg_data[14:0];
                CFG_NEUTRAL_RATE:        neutral_rate_reg        <= cfg_data[14:0];
                CFG_COOLDOWN_MS:         cooldown_ms_reg         <= cfg_data;
                CFG_POLL_INTERVAL_MS:    poll_interval_ms_reg    <= cfg_data;
                CFG_WAKE_SETTLE_MS:      wake_settle_ms_reg      <= cfg_data;
                CFG_FACE_DOWN_MIN:       face_down_min_reg       <= cfg_data[14:0];
                CFG_FACE_DOWN_MAX_ORTHO: face_down_max_ortho_reg <= cfg_data[14:0];
                CFG_BOARD_FLAGS:         board_flags_reg         <= cfg_data[1:0];
                default:                 board_flags_reg         <= board_flags_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awake_reg               <= 1'b0;
            holding_tilt_reg        <= 1'b0;
            face_down_valid_reg     <= 1'b0;
            wake_time_reg           <= 32'd0;
            last_poll_time_reg      <= 32'd0;
            last_trigger_time_reg   <= 32'd0;
            last_face_poll_time_reg <= 32'd0;
            face_down_since_reg     <= 32'd0;
        end
        else if (fire)
        begin
            awake_reg               <= awake_next;
            holding_tilt_reg        <= holding_tilt_next;
            face_down_valid_reg     <= face_down_valid_next;
            wake_time_reg           <= wake_time_next;
            last_poll_time_reg      <= last_poll_time_next;
            last_trigger_time_reg   <= last_trigger_time_next;
            last_face_poll_time_reg <= last_face_poll_time_next;
            face_down_since_reg     <= face_down_since_next;
        end
    end

    // input stage and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                result_valid_reg <= stage_valid_reg;
            end
            if (!sample_stall)
            begin
                stage_valid_reg <= sample_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            stage_reg <= sample;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.tilt_forward && result.tilt_back))
        else $error("both tilt pulses in one item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.face_down_active) |-> (result.face_down_start == 32'd0))
        else $error("face-down start set while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && wake_cond) |=> (awake_reg && result_valid && result.power_request == PWR_WAKE))
        else $error("wake item did not wake the sensor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.tilt_forward || result.tilt_back)) |-> result.sensor_awake)
        else $error("tilt pulse while sensor asleep");

endmodule
